@@ rtl/gamepad_report_to_key_events_macros.svh @@
// Assertion macros for the gamepad report to key events block.
// Has no dependencies. Files that check their own logic include this header.
`ifndef GAMEPAD_REPORT_TO_KEY_EVENTS_MACROS_SVH
`define GAMEPAD_REPORT_TO_KEY_EVENTS_MACROS_SVH

`ifndef SYNTHESIS
`define GPKE_ASSERT_NEVER(lbl, ck, rs, expr, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(expr)) else $error(msg);
`define GPKE_ASSERT_IMPLY(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
`define GPKE_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define GPKE_ASSERT_NEVER(lbl, ck, rs, expr, msg)
`define GPKE_ASSERT_IMPLY(lbl, ck, rs, ante, cons, msg)
`define GPKE_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`endif

`endif

@@ rtl/gpke_pkg.sv @@
// Shared constants, types and the key id lookup for the gamepad key event block.
// Has no dependencies; the RTL modules and the testbench refer to it by scoped names.
package gpke_pkg;

  localparam int NUM_BUTTONS = 12;
  localparam int NUM_DIRS    = 4;
  localparam int NUM_MAPPED  = 8;
  localparam int NUM_EVENTS  = NUM_DIRS + NUM_MAPPED;
  localparam int EV_IDX_W    = $clog2(NUM_EVENTS);
  localparam int BTN_IDX_W   = $clog2(NUM_MAPPED);
  localparam int RAW_BTN_W   = 16;

  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] AXIS_CENTER = 8'h7F;
  localparam logic [7:0] AXIS_MIN    = 8'h00;
  localparam logic [7:0] AXIS_MAX    = 8'hFF;

  // direction map bit positions
  localparam int DIR_UP    = 0;
  localparam int DIR_DOWN  = 1;
  localparam int DIR_LEFT  = 2;
  localparam int DIR_RIGHT = 3;

  localparam logic [6:0] DIR_CODE_BASE = 7'd9;
  localparam logic [6:0] BUTTON_IDS [NUM_MAPPED] =
    '{7'd4, 7'd3, 7'd2, 7'd1, 7'd5, 7'd6, 7'd8, 7'd7};

  // pend: events still to send, level: new held state of each event source
  typedef struct packed {
    logic [NUM_EVENTS-1:0] pend;
    logic [NUM_EVENTS-1:0] level;
  } entry_t;

  function automatic logic [6:0] event_id(input logic [EV_IDX_W-1:0] idx);
    logic [EV_IDX_W-1:0] b;
    begin
      b = idx - EV_IDX_W'(NUM_DIRS);
      if (idx < EV_IDX_W'(NUM_DIRS)) begin
        return DIR_CODE_BASE + 7'(idx);
      end
      return BUTTON_IDS[b[BTN_IDX_W-1:0]];
    end
  endfunction

endpackage

@@ rtl/gpke_if.sv @@
// Valid/ready channel interfaces: gamepad reports in, key events out.
// Has no dependencies.
interface gpke_report_if;
  logic       valid;
  logic       ready;
  logic [7:0] axis_horizontal;
  logic [7:0] axis_vertical;
  logic [7:0] button_low_byte;
  logic [7:0] button_high_byte;

  modport source (output valid, axis_horizontal, axis_vertical, button_low_byte,
                  button_high_byte, input ready);
  modport sink (input valid, axis_horizontal, axis_vertical, button_low_byte,
                button_high_byte, output ready);
endinterface

interface gpke_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_code;
  logic       last_event;

  modport source (output valid, key_code, last_event, input ready);
  modport sink (input valid, key_code, last_event, output ready);
endinterface

@@ rtl/gpke_front.sv @@
// Front end: accepts reports, tracks direction map and button image,
// and builds a mask of pending events. Depends on gpke_pkg and gpke_if.
module gpke_front (
  input  logic              clk,
  input  logic              rst,
  gpke_report_if.sink       report,
  input  logic              q_full,
  output logic              push,
  output gpke_pkg::entry_t  push_entry
);

  logic [gpke_pkg::NUM_DIRS-1:0]    dir_map;
  logic [gpke_pkg::NUM_DIRS-1:0]    dir_map_next;
  logic [gpke_pkg::NUM_BUTTONS-1:0] button_image;
  logic [gpke_pkg::NUM_BUTTONS-1:0] img;
  logic [gpke_pkg::NUM_BUTTONS-1:0] chg;
  logic [gpke_pkg::RAW_BTN_W-1:0]   raw;
  logic                             accept;
  logic                             h_c, h_lo, h_hi, v_c, v_lo, v_hi;

  assign report.ready = !q_full;
  assign accept       = report.valid && report.ready;

  assign h_c  = report.axis_horizontal == gpke_pkg::AXIS_CENTER;
  assign h_lo = report.axis_horizontal == gpke_pkg::AXIS_MIN;
  assign h_hi = report.axis_horizontal == gpke_pkg::AXIS_MAX;
  assign v_c  = report.axis_vertical == gpke_pkg::AXIS_CENTER;
  assign v_lo = report.axis_vertical == gpke_pkg::AXIS_MIN;
  assign v_hi = report.axis_vertical == gpke_pkg::AXIS_MAX;

  always_comb begin
    dir_map_next = dir_map;
    if (h_c && v_c) begin
      dir_map_next = '0;
    end else begin
      if (h_c && v_lo) dir_map_next[gpke_pkg::DIR_UP]    = 1'b1;
      if (h_c && v_hi) dir_map_next[gpke_pkg::DIR_DOWN]  = 1'b1;
      if (h_lo && v_c) dir_map_next[gpke_pkg::DIR_LEFT]  = 1'b1;
      if (h_hi && v_c) dir_map_next[gpke_pkg::DIR_RIGHT] = 1'b1;
    end
  end

  assign raw = {4'b0000, report.button_high_byte, report.button_low_byte[7:4]};
  assign img = raw[gpke_pkg::NUM_BUTTONS-1:0];
  assign chg = img ^ button_image;

  assign push_entry.pend  = {chg[gpke_pkg::NUM_MAPPED-1:0], dir_map_next ^ dir_map};
  assign push_entry.level = {img[gpke_pkg::NUM_MAPPED-1:0], dir_map_next};
  assign push             = accept && (|push_entry.pend);

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_map      <= '0;
      button_image <= '0;
    end else if (accept) begin
      dir_map      <= dir_map_next;
      button_image <= img;
    end
  end

endmodule

@@ rtl/gpke_fifo.sv @@
// Short queue of pending event masks between front and back ends.
// Depends on gpke_pkg and the assertion macro header.
`include "gamepad_report_to_key_events_macros.svh"

module gpke_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  gpke_pkg::entry_t  push_entry,
  input  logic              pop,
  output gpke_pkg::entry_t  pop_entry,
  output logic              full,
  output logic              empty
);

  gpke_pkg::entry_t             mem [gpke_pkg::FIFO_DEPTH];
  logic [gpke_pkg::FIFO_AW-1:0] wr_ptr;
  logic [gpke_pkg::FIFO_AW-1:0] rd_ptr;
  logic [gpke_pkg::FIFO_CW-1:0] count;

  assign full      = count == gpke_pkg::FIFO_CW'(gpke_pkg::FIFO_DEPTH);
  assign empty     = count == '0;
  assign pop_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `GPKE_ASSERT_NEVER(a_no_overflow, clk, rst, push && full && !pop, "push into full queue")
  `GPKE_ASSERT_NEVER(a_no_underflow, clk, rst, pop && empty, "pop from empty queue")
  `GPKE_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1, "count did not rise")

endmodule

@@ rtl/gpke_back.sv @@
// Back end: walks the pending mask lowest event first and sends one key
// code per transaction through an output register. Depends on gpke_pkg, gpke_if.
module gpke_back (
  input  logic              clk,
  input  logic              rst,
  input  gpke_pkg::entry_t  q_entry,
  input  logic              q_empty,
  output logic              pop,
  gpke_key_if.source        keys
);

  gpke_pkg::entry_t                cur;
  logic [gpke_pkg::NUM_EVENTS-1:0] rest;
  logic [gpke_pkg::EV_IDX_W-1:0]   idx;
  logic                            busy;
  logic                            load_out;
  logic                            step;
  logic                            out_valid;
  logic [7:0]                      key_code;
  logic                            last_event;

  always_comb begin
    idx = '0;
    for (int i = gpke_pkg::NUM_EVENTS - 1; i >= 0; i--) begin
      if (cur.pend[i]) idx = gpke_pkg::EV_IDX_W'(i);
    end
  end

  assign busy     = |cur.pend;
  assign rest     = cur.pend & (cur.pend - 1'b1);
  assign load_out = !out_valid || keys.ready;
  assign step     = busy && load_out;
  assign pop      = !q_empty && (!busy || (step && rest == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.pend  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur.pend  <= q_entry.pend;
        cur.level <= q_entry.level;
      end else if (step) begin
        cur.pend <= rest;
      end
      if (load_out) out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      key_code   <= {~cur.level[idx], gpke_pkg::event_id(idx)};
      last_event <= rest == '0;
    end
  end

  assign keys.valid      = out_valid;
  assign keys.key_code   = key_code;
  assign keys.last_event = last_event;

endmodule

@@ rtl/gamepad_report_to_key_events.sv @@
// Top level of the gamepad report to key event converter.
// Depends on gpke_pkg, gpke_if, gpke_front, gpke_fifo and gpke_back.
//
//   channel  role    transaction
//   report   sink    one report: two axis bytes, two button bytes
//   keys     source  one key code with a last flag
//
// A report is taken while the two-entry queue has room; the back end
// sends one key code per cycle while keys.ready is high; a report
// causes zero to 12 key events. The first key code of a report passes
// the queue, the pending mask and the output register. Reports with
// no events leave no trace in the queue. Reset (rst, synchronous)
// clears held directions, button image, the queue and the output valid
// flag. A stall on keys fills the queue and then holds report.ready low.
module gamepad_report_to_key_events (
  input  logic        clk,
  input  logic        rst,
  gpke_report_if.sink report,
  gpke_key_if.source  keys
);

  gpke_pkg::entry_t push_entry;
  gpke_pkg::entry_t pop_entry;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;

  gpke_front u_front (
    .clk        (clk),
    .rst        (rst),
    .report     (report),
    .q_full     (full),
    .push       (push),
    .push_entry (push_entry)
  );

  gpke_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .full       (full),
    .empty      (empty)
  );

  gpke_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_entry (pop_entry),
    .q_empty (empty),
    .pop     (pop),
    .keys    (keys)
  );

endmodule

@@ tb/sv/tb_gamepad_report_to_key_events.sv @@
// Self-checking testbench for gamepad_report_to_key_events: directed table, then random reports.
// Depends on gpke_pkg, gpke_if (gpke_report_if, gpke_key_if) and the block's RTL.
module tb_gamepad_report_to_key_events;

  localparam logic [7:0] CENTER    = 8'h7F;
  localparam logic [7:0] AXIS_LOW  = 8'h00;
  localparam logic [7:0] AXIS_HIGH = 8'hFF;
  localparam logic [7:0] AXIS_CHOICES [3] = '{AXIS_LOW, CENTER, AXIS_HIGH};

  localparam int UP_BIT    = 0;
  localparam int DOWN_BIT  = 1;
  localparam int LEFT_BIT  = 2;
  localparam int RIGHT_BIT = 3;
  localparam int DIR_COUNT = 4;
  localparam logic [6:0] FIRST_DIR_CODE = 7'd9;

  localparam int MAPPED_BUTTONS = 8;
  localparam logic [6:0] KEY_ID_OF_BUTTON [MAPPED_BUTTONS] =
    '{7'd4, 7'd3, 7'd2, 7'd1, 7'd5, 7'd6, 7'd8, 7'd7};

  localparam logic TYPED     = 1'b1;
  localparam logic PREDICTED = 1'b0;

  localparam int RANDOM_REPORTS    = 234;
  localparam int LONG_STALL_AFTER  = 60;
  localparam int LONG_STALL_CYCLES = 150;
  localparam int DRAIN_CYCLES      = 40;
  localparam int CYCLE_LIMIT       = 200000;

  typedef struct packed {
    logic [7:0]      horiz;
    logic [7:0]      vert;
    logic [7:0]      btn_lo;
    logic [7:0]      btn_hi;
    logic            typed;
    logic [2:0]      n_typed;
    logic [3:0][7:0] codes;
  } report_row_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } key_event_t;

  localparam int DIRECTED_COUNT = 26;
  localparam report_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{8'h7F, 8'h7F, 8'h00, 8'h00, TYPED,     3'd0, 32'h0},
    '{8'h7F, 8'h00, 8'h00, 8'h00, TYPED,     3'd1, 32'h09},
    '{8'hFF, 8'h7F, 8'h00, 8'h00, TYPED,     3'd1, 32'h0C},
    '{8'h7F, 8'hFF, 8'h00, 8'h00, TYPED,     3'd1, 32'h0A},
    '{8'h00, 8'h7F, 8'h00, 8'h00, TYPED,     3'd1, 32'h0B},
    '{8'h7F, 8'h7F, 8'h00, 8'h00, TYPED,     3'd4, 32'h8C8B8A89},
    '{8'h00, 8'h00, 8'hF0, 8'h00, PREDICTED, 3'd0, 32'h0},
    '{8'hFF, 8'hFF, 8'h0F, 8'hFF, PREDICTED, 3'd0, 32'h0},
    '{8'h7E, 8'h00, 8'hFF, 8'hFF, PREDICTED, 3'd0, 32'h0},
    '{8'h7F, 8'h01, 8'hFF, 8'hFF, TYPED,     3'd0, 32'h0},
    '{8'hFE, 8'h7F, 8'hFF, 8'hFF, TYPED,     3'd0, 32'h0},
    '{8'h7F, 8'hFE, 8'hFF, 8'hFF, TYPED,     3'd0, 32'h0},
    '{8'h01, 8'h7F, 8'hFF, 8'hFF, TYPED,     3'd0, 32'h0},
    '{8'h80, 8'h7F, 8'hFF, 8'hFF, TYPED,     3'd0, 32'h0},
    '{8'h7F, 8'h00, 8'hF0, 8'hFF, PREDICTED, 3'd0, 32'h0},
    '{8'h7F, 8'hFF, 8'hF0, 8'hFF, PREDICTED, 3'd0, 32'h0},
    '{8'h00, 8'h7F, 8'hF0, 8'hFF, PREDICTED, 3'd0, 32'h0},
    '{8'hFF, 8'h7F, 8'hF0, 8'hFF, PREDICTED, 3'd0, 32'h0},
    '{8'h7F, 8'h7F, 8'h00, 8'h00, PREDICTED, 3'd0, 32'h0},
    '{8'h7F, 8'h7F, 8'h00, 8'hF0, TYPED,     3'd0, 32'h0},
    '{8'h7F, 8'h7F, 8'h00, 8'h0F, PREDICTED, 3'd0, 32'h0},
    '{8'h7F, 8'h7F, 8'h10, 8'h00, PREDICTED, 3'd0, 32'h0},
    '{8'h7F, 8'h7F, 8'h20, 8'h00, PREDICTED, 3'd0, 32'h0},
    '{8'h7F, 8'h7F, 8'h40, 8'h00, PREDICTED, 3'd0, 32'h0},
    '{8'h7F, 8'h7F, 8'h80, 8'h00, PREDICTED, 3'd0, 32'h0},
    '{8'hFF, 8'h00, 8'h00, 8'h00, PREDICTED, 3'd0, 32'h0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  gpke_report_if report_ch ();
  gpke_key_if    keys_ch ();

  gamepad_report_to_key_events u_dut (
    .clk    (clk),
    .rst    (rst),
    .report (report_ch),
    .keys   (keys_ch)
  );

  always #5 clk = ~clk;

  logic [3:0]                      held_dirs    = '0;
  logic [gpke_pkg::NUM_BUTTONS-1:0] held_buttons = '0;
  logic [7:0]                      fresh_codes [$];
  key_event_t                      expected_keys [$];

  int errors     = 0;
  int keys_seen  = 0;
  int cycle_count = 0;
  bit send_calm  = 1'b0;
  bit sink_calm  = 1'b0;

  function automatic void predict_key_events(input logic [7:0] horiz, vert, btn_lo, btn_hi);
    logic [3:0]                      next_dirs;
    logic [gpke_pkg::NUM_BUTTONS-1:0] image;
    logic [gpke_pkg::NUM_BUTTONS-1:0] changed;
    fresh_codes.delete();
    if (horiz == CENTER && vert == CENTER) begin
      next_dirs = '0;
    end else begin
      next_dirs = held_dirs;
      if (horiz == CENTER && vert == AXIS_LOW) next_dirs[UP_BIT] = 1'b1;
      if (horiz == AXIS_HIGH && vert == CENTER) next_dirs[RIGHT_BIT] = 1'b1;
      if (horiz == CENTER && vert == AXIS_HIGH) next_dirs[DOWN_BIT] = 1'b1;
      if (horiz == AXIS_LOW && vert == CENTER) next_dirs[LEFT_BIT] = 1'b1;
    end
    for (int i = 0; i < DIR_COUNT; i++) begin
      if (next_dirs[i] != held_dirs[i]) begin
        fresh_codes.push_back({~next_dirs[i], FIRST_DIR_CODE + 7'(i)});
      end
    end
    held_dirs = next_dirs;
    image   = {btn_hi, btn_lo[7:4]};
    changed = image ^ held_buttons;
    // buttons beyond the mapped ones are tracked but stay silent
    for (int i = 0; i < MAPPED_BUTTONS; i++) begin
      if (changed[i]) begin
        fresh_codes.push_back({~image[i], KEY_ID_OF_BUTTON[i]});
      end
    end
    held_buttons = image;
  endfunction

  task automatic send_report(input report_row_t row, output int n_events);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 3);
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    if (gap > 0) begin
      report_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    report_ch.valid            <= 1'b1;
    report_ch.axis_horizontal  <= row.horiz;
    report_ch.axis_vertical    <= row.vert;
    report_ch.button_low_byte  <= row.btn_lo;
    report_ch.button_high_byte <= row.btn_hi;
    @(posedge clk);
    while (!report_ch.ready) @(posedge clk);
    predict_key_events(row.horiz, row.vert, row.btn_lo, row.btn_hi);
    if (row.typed) begin
      fresh_codes.delete();
      for (int k = 0; k < int'(row.n_typed); k++) fresh_codes.push_back(row.codes[k]);
    end
    n_events = fresh_codes.size();
    for (int k = 0; k < n_events; k++) begin
      expected_keys.push_back('{code: fresh_codes[k], last: (k == n_events - 1)});
    end
  endtask

  initial begin : report_source
    report_row_t row;
    logic [7:0]  horiz;
    logic [7:0]  vert;
    logic [15:0] buttons;
    int          n_events;
    report_ch.valid            <= 1'b0;
    report_ch.axis_horizontal  <= '0;
    report_ch.axis_vertical    <= '0;
    report_ch.button_low_byte  <= '0;
    report_ch.button_high_byte <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_COUNT; r++) begin
      send_report(DIRECTED_ROWS[r], n_events);
    end

    buttons  = 16'h0000;
    for (int r = 0; r < RANDOM_REPORTS; r++) begin
      case ($urandom_range(0, 9))
        0: {horiz, vert} = {CENTER, CENTER};
        1: {horiz, vert} = {CENTER, AXIS_LOW};
        2: {horiz, vert} = {CENTER, AXIS_HIGH};
        3: {horiz, vert} = {AXIS_LOW, CENTER};
        4: {horiz, vert} = {AXIS_HIGH, CENTER};
        5, 6: begin
          horiz = AXIS_CHOICES[$urandom_range(0, 2)];
          vert  = AXIS_CHOICES[$urandom_range(0, 2)];
        end
        default: begin
          horiz = 8'($urandom);
          vert  = 8'($urandom);
        end
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          repeat ($urandom_range(1, 3)) buttons = buttons ^ (16'h1 << $urandom_range(0, 15));
        end
        5, 6: ;
        default: buttons = 16'($urandom);
      endcase
      row = '{horiz, vert, buttons[7:0], buttons[15:8], PREDICTED, 3'd0, 32'h0};
      send_report(row, n_events);
    end
    report_ch.valid <= 1'b0;

    while (expected_keys.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_keys.size() != 0) begin
      $display("%0t: %0d key events never arrived", $time, expected_keys.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : key_sink
    int         hold;
    key_event_t want;
    hold = 0;
    keys_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (keys_ch.valid && keys_ch.ready) begin
          if (expected_keys.size() == 0) begin
            $display("%0t: unexpected key transaction, expected none, got code %02h last %0b",
                     $time, keys_ch.key_code, keys_ch.last_event);
            errors++;
          end else begin
            want = expected_keys.pop_front();
            if (keys_ch.key_code !== want.code) begin
              $display("%0t: key_code expected %02h got %02h", $time, want.code,
                       keys_ch.key_code);
              errors++;
            end
            if (keys_ch.last_event !== want.last) begin
              $display("%0t: last_event expected %0b got %0b", $time, want.last,
                       keys_ch.last_event);
              errors++;
            end
          end
          keys_seen++;
          if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
          hold = sink_calm ? 0 : $urandom_range(0, 3);
          // long hold-off so the queue fills and report.ready drops
          if (keys_seen == LONG_STALL_AFTER) hold = LONG_STALL_CYCLES;
        end else if (hold > 0) begin
          hold--;
        end
        keys_ch.ready <= (hold == 0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run timed out with %0d key events pending", $time, expected_keys.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/gpke_pkg.sv
rtl/gpke_if.sv
rtl/gpke_front.sv
rtl/gpke_fifo.sv
rtl/gpke_back.sv
rtl/gamepad_report_to_key_events.sv
tb/sv/tb_gamepad_report_to_key_events.sv
